@@ src/aigsim_pkg.sv @@
// Shared types, codes and microprogram of the and-inverter graph simulator.
`default_nettype none

package aigsim_pkg;

	// Operation codes of an input item
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_AND   = 2'd1;
	localparam logic [1:0] OP_COPY  = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	// Configuration register index
	localparam logic REG_ACTIVE_WORDS = 1'b0;

	localparam logic [2:0]  ACTIVE_WORDS_RST = 3'd4;
	localparam logic [31:0] ALL_ONES         = 32'hffff_ffff;

	// Input item
	typedef struct packed {
		logic [1:0]  op;
		logic [9:0]  node_id;
		logic [9:0]  fanin_a;
		logic [9:0]  fanin_b;
		logic        invert_a;
		logic        invert_b;
		logic [1:0]  word_index;
		logic [31:0] pattern_word;
	} item_t;

	// Result item
	typedef struct packed {
		logic [31:0] read_word;
		logic        is_read;
	} result_t;

	// Microprogram addresses
	typedef logic [3:0] upc_t;
	localparam upc_t S_IDLE = 4'd0;
	localparam upc_t S_WR   = 4'd1;
	localparam upc_t S_AND0 = 4'd2;
	localparam upc_t S_AND1 = 4'd3;
	localparam upc_t S_CPY0 = 4'd4;
	localparam upc_t S_CPY1 = 4'd5;
	localparam upc_t S_EMIT = 4'd6;
	localparam upc_t S_RD1  = 4'd7;
	localparam upc_t S_RD0  = 4'd8;

	// Next-step selection
	typedef enum logic [2:0] {
		COND_ALWAYS   = 3'd0,  // go to target
		COND_DISPATCH = 3'd1,  // on accept, go to the entry of the op
		COND_ZERO     = 3'd2,  // no active words: target, else next step
		COND_LOOP     = 3'd3,  // more words: stay, else target
		COND_WAIT     = 3'd4   // output slot free: target, else stay
	} cond_t;

	// One control word
	typedef struct packed {
		logic  rd_fanin;  // read the fanins at the read word counter (the second only with use_b)
		logic  rd_node;   // read node_id at word_index
		logic  wr_pat;    // write pattern_word to node_id at word_index
		logic  wr_logic;  // write the gate result at the write word counter
		logic  use_b;     // gate uses the second fanin
		logic  emit;      // load the output register
		logic  is_read;   // result carries read data
		cond_t cond;
		upc_t  target;
	} ctrl_t;

	// Status fed back into the sequencer
	typedef struct packed {
		logic       accept;
		logic [1:0] op;
		logic       zero;
		logic       more;
		logic       slot_free;
	} seq_flags_t;

	// Microprogram ROM
	function automatic ctrl_t ucode(upc_t addr);
		ctrl_t cw;
		cw = '{rd_fanin: 1'b0, rd_node: 1'b0, wr_pat: 1'b0, wr_logic: 1'b0, use_b: 1'b0,
			emit: 1'b0, is_read: 1'b0, cond: COND_DISPATCH, target: S_IDLE};
		unique case (addr)
			S_IDLE: begin
				cw.cond = COND_DISPATCH;
			end
			S_WR: begin
				cw.wr_pat = 1'b1;
				cw.cond   = COND_ALWAYS;
				cw.target = S_EMIT;
			end
			S_AND0: begin
				cw.rd_fanin = 1'b1;
				cw.use_b    = 1'b1;
				cw.cond     = COND_ZERO;
				cw.target   = S_EMIT;
			end
			S_AND1: begin
				cw.rd_fanin = 1'b1;
				cw.wr_logic = 1'b1;
				cw.use_b    = 1'b1;
				cw.cond     = COND_LOOP;
				cw.target   = S_EMIT;
			end
			S_CPY0: begin
				cw.rd_fanin = 1'b1;
				cw.cond     = COND_ZERO;
				cw.target   = S_EMIT;
			end
			S_CPY1: begin
				cw.rd_fanin = 1'b1;
				cw.wr_logic = 1'b1;
				cw.cond     = COND_LOOP;
				cw.target   = S_EMIT;
			end
			S_EMIT: begin
				cw.emit   = 1'b1;
				cw.cond   = COND_WAIT;
				cw.target = S_IDLE;
			end
			S_RD1: begin
				cw.emit    = 1'b1;
				cw.is_read = 1'b1;
				cw.cond    = COND_WAIT;
				cw.target  = S_IDLE;
			end
			S_RD0: begin
				cw.rd_node = 1'b1;
				cw.cond    = COND_ALWAYS;
				cw.target  = S_RD1;
			end
			default: begin
				cw.cond   = COND_ALWAYS;
				cw.target = S_IDLE;
			end
		endcase
		return cw;
	endfunction

	// Entry step of each operation
	function automatic upc_t dispatch(logic [1:0] op);
		upc_t entry;
		unique case (op)
			OP_WRITE: entry = S_WR;
			OP_AND:   entry = S_AND0;
			OP_COPY:  entry = S_CPY0;
			OP_READ:  entry = S_RD0;
			default:  entry = S_IDLE;
		endcase
		return entry;
	endfunction

endpackage

`default_nettype wire

@@ src/aigsim_ram.sv @@
// Generic RAM: one write port, two registered read ports.
`default_nettype none

module aigsim_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic      [WIDTH-1:0]         rdata_a,
	input  wire logic                     re_b,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read ports
	always_ff @(posedge clk) begin
		if (re_a) begin
			rdata_a <= mem_q[raddr_a];
		end
		if (re_b) begin
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

`default_nettype wire

@@ src/aigsim_useq.sv @@
// Microcode sequencer: step counter, control ROM and jump logic.
`default_nettype none

module aigsim_useq
	import aigsim_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire seq_flags_t flags,
	output ctrl_t           cw
);

	upc_t upc_q;
	upc_t upc_nxt;

	assign cw = ucode(upc_q);

	// Next step
	always_comb begin
		unique case (cw.cond)
			COND_ALWAYS:   upc_nxt = cw.target;
			COND_DISPATCH: upc_nxt = flags.accept ? dispatch(flags.op) : upc_q;
			COND_ZERO:     upc_nxt = flags.zero ? cw.target : upc_t'(upc_q + 1'b1);
			COND_LOOP:     upc_nxt = flags.more ? upc_q : cw.target;
			COND_WAIT:     upc_nxt = flags.slot_free ? cw.target : upc_q;
			default:       upc_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_IDLE;
		end else begin
			upc_q <= upc_nxt;
		end
	end

endmodule

`default_nettype wire

@@ src/aig_bit_parallel_simulator.sv @@
// Top level of the bit-parallel and-inverter graph simulator.
//
// Keeps WORDS_PER_NODE 32-bit simulation words for each of NUM_NODES nodes in
// one RAM and runs one item at a time under a small microprogram. A write
// stores its word in S_WR, a read fetches its word in S_RD0, and the result is
// then loaded into the output register in S_EMIT or S_RD1. An AND or an output
// copy loops over the n active words (n being the active word count, saturated
// to WORDS_PER_NODE), the single RAM write port storing one gate word per cycle
// while the next fanin words are fetched alongside. The next item is taken in
// the cycle after the result is loaded; a result still waiting in the output
// register holds the sequencer until it is taken. Node 0 reads as all ones and
// is never written. The store is not cleared at reset: read words only after
// they were written. active_words lives at byte address 0.
`default_nettype none

module aig_bit_parallel_simulator
	import aigsim_pkg::*;
#(
	parameter int NUM_NODES      = 1024,
	parameter int WORDS_PER_NODE = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Item input
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire item_t       in_data,
	// Result output
	output logic             out_valid,
	input  wire logic        out_ready,
	output result_t          out_data,
	// Configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	localparam int WBITS   = (WORDS_PER_NODE > 1) ? $clog2(WORDS_PER_NODE) : 1;
	localparam int NBITS   = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
	localparam int NEXT    = (NBITS > 10) ? NBITS : 10;
	localparam int ABITS   = NBITS + WBITS;
	localparam int DEPTH   = NUM_NODES * (2 ** WBITS);
	localparam int WPN_CAP = (WORDS_PER_NODE > 7) ? 7 : WORDS_PER_NODE;

	// Store address of one word of one node
	function automatic logic [ABITS-1:0] word_addr(logic [9:0] node, logic [WBITS-1:0] w);
		logic [NEXT-1:0] node_ext;
		node_ext = NEXT'(node);
		return {node_ext[NBITS-1:0], w};
	endfunction

	ctrl_t       cw;
	seq_flags_t  flags;
	item_t       item_q;
	logic [2:0]  active_q;
	logic [2:0]  n_words;
	logic [2:0]  k_r_q;
	logic [2:0]  k_w_q;
	logic        accept;
	logic        slot_free;
	logic        out_load;
	logic        out_valid_q;
	result_t     out_q;
	logic        rd_more;
	logic        node_ok;
	logic        wi_ok;
	logic        ram_we;
	logic [ABITS-1:0] ram_waddr;
	logic [31:0] ram_wdata;
	logic        ram_re_a;
	logic        ram_re_b;
	logic [ABITS-1:0] ram_raddr_a;
	logic [ABITS-1:0] ram_raddr_b;
	logic [31:0] ram_rdata_a;
	logic [31:0] ram_rdata_b;
	logic [31:0] fa_word;
	logic [31:0] fb_word;
	logic [31:0] gate_word;
	logic [31:0] node_word;

	// Configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ACTIVE_WORDS) ? {29'd0, active_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_WORDS_RST;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_ACTIVE_WORDS) begin
			active_q <= pwdata[2:0];
		end
	end

	// Words simulated per node, saturated to WORDS_PER_NODE (and at most 7)
	assign n_words = (active_q > 3'(WPN_CAP)) ? 3'(WPN_CAP) : active_q;

	// Sequencer
	assign in_ready  = (cw.cond == COND_DISPATCH);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign rd_more   = (k_r_q < n_words);

	assign flags.accept    = accept;
	assign flags.op        = in_data.op;
	assign flags.zero      = (n_words == 3'd0);
	assign flags.more      = ((4'(k_w_q) + 4'd1) < 4'(n_words));
	assign flags.slot_free = slot_free;

	aigsim_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.cw     (cw)
	);

	// Item register and word counters
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_r_q <= '0;
			k_w_q <= '0;
		end else if (accept) begin
			k_r_q <= '0;
			k_w_q <= '0;
		end else begin
			if (cw.rd_fanin && rd_more) begin
				k_r_q <= k_r_q + 3'd1;
			end
			if (cw.wr_logic) begin
				k_w_q <= k_w_q + 3'd1;
			end
		end
	end

	// Range checks on the held item
	assign node_ok = (item_q.node_id != 10'd0) && (int'(item_q.node_id) < NUM_NODES);
	assign wi_ok   = (int'(item_q.word_index) < WORDS_PER_NODE);

	// Store access
	assign ram_re_a    = cw.rd_node || (cw.rd_fanin && rd_more);
	assign ram_re_b    = cw.rd_fanin && cw.use_b && rd_more;
	assign ram_raddr_a = cw.rd_node ? word_addr(item_q.node_id, WBITS'(item_q.word_index))
	                                : word_addr(item_q.fanin_a, WBITS'(k_r_q));
	assign ram_raddr_b = word_addr(item_q.fanin_b, WBITS'(k_r_q));

	assign ram_we    = (cw.wr_pat && node_ok && wi_ok) || (cw.wr_logic && node_ok);
	assign ram_waddr = cw.wr_pat ? word_addr(item_q.node_id, WBITS'(item_q.word_index))
	                             : word_addr(item_q.node_id, WBITS'(k_w_q));
	assign ram_wdata = cw.wr_pat ? item_q.pattern_word : gate_word;

	aigsim_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re_a    (ram_re_a),
		.raddr_a (ram_raddr_a),
		.rdata_a (ram_rdata_a),
		.re_b    (ram_re_b),
		.raddr_b (ram_raddr_b),
		.rdata_b (ram_rdata_b)
	);

	// Fanin words: out-of-range nodes read zero, the constant node all ones
	always_comb begin
		if (int'(item_q.fanin_a) >= NUM_NODES) begin
			fa_word = 32'd0;
		end else if (item_q.fanin_a == 10'd0) begin
			fa_word = ALL_ONES;
		end else begin
			fa_word = ram_rdata_a;
		end
		if (int'(item_q.fanin_b) >= NUM_NODES) begin
			fb_word = 32'd0;
		end else if (item_q.fanin_b == 10'd0) begin
			fb_word = ALL_ONES;
		end else begin
			fb_word = ram_rdata_b;
		end
	end

	// Gate: AND of two optionally inverted fanins, or a copy of the first
	assign gate_word = (fa_word ^ {32{item_q.invert_a}})
		& (cw.use_b ? (fb_word ^ {32{item_q.invert_b}}) : ALL_ONES);

	// Word for a read item
	always_comb begin
		if (int'(item_q.node_id) >= NUM_NODES || !wi_ok) begin
			node_word = 32'd0;
		end else if (item_q.node_id == 10'd0) begin
			node_word = ALL_ONES;
		end else begin
			node_word = ram_rdata_a;
		end
	end

	// Output register
	assign out_load = cw.emit && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.read_word <= cw.is_read ? node_word : 32'd0;
			out_q.is_read   <= cw.is_read;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTH
	// The constant node and nodes beyond the store are never written
	a_no_const_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (item_q.node_id != 10'd0 && int'(item_q.node_id) < NUM_NODES))
		else $error("store write to a node that must stay untouched");

	// One item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("item accepted while another is in progress");

	// Gate writes stay within the active words
	a_word_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cw.wr_logic |-> (k_w_q < n_words))
		else $error("gate write past the active words");

	// No result in the cycle right after acceptance
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !out_load)
		else $error("result produced before any work");
`endif

endmodule

`default_nettype wire
